// ===== rtl/spm_pkg.sv =====
// Package: constants, codes and types for the sparse polynomial multiplier.
package spm_pkg;

    localparam int TERMS      = 8;
    localparam int TIDX_W     = $clog2(TERMS);
    localparam int TCNT_W     = $clog2(TERMS + 1);
    localparam int PDEPTH     = TERMS * TERMS;
    localparam int PIDX_W     = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
    localparam int PCNT_W     = $clog2(PDEPTH + 1);
    localparam int COEF_W     = 32;
    localparam int POW_W      = 8;
    localparam int PPOW_W     = 9;
    localparam int TERM_W     = COEF_W + POW_W;
    localparam int PTERM_W    = COEF_W + PPOW_W;

    typedef enum logic [1:0] {
        OP_ADD_FIRST  = 2'd0,
        OP_ADD_SECOND = 2'd1,
        OP_PRODUCT    = 2'd2,
        OP_CLEAR      = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_APPENDED = 3'd0,
        ST_MERGED   = 3'd1,
        ST_DROPPED  = 3'd2,
        ST_TERM     = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_CLEARED  = 3'd5
    } status_t;

    // Sequencer states, one-hot
    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_SCAN   = 10'b0000000010,  // search a table for a power
        S_ADDWR  = 10'b0000000100,  // write merged/appended term
        S_PRD    = 10'b0000001000,  // read pair operands
        S_MUL    = 10'b0000010000,  // multiply
        S_PSCAN  = 10'b0000100000,  // search product table
        S_PWR    = 10'b0001000000,  // write product entry
        S_EMIT   = 10'b0010000000,  // read product entry for output
        S_EMITW  = 10'b0100000000,  // product word waits for output slot
        S_RESP   = 10'b1000000000   // single-word response
    } state_t;

endpackage

// ===== rtl/spm_ram.sv =====
// Generic single-port synchronous RAM with registered read.
module spm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/sparse_polynomial_multiply.sv =====
// Sparse polynomial multiplier: term tables in RAM with a read-modify-write sequencer.
// Add term: one pass over the stored terms, then a write of the merged or appended term.
// Product: for each pair, read, multiply, product-table search and write; then each stored
// product term is read and emitted as one word. The single-port RAM reads set the rate.
// One word in flight at a time.
// rst_n clears counts and control asynchronously; RAM contents are not cleared.
module sparse_polynomial_multiply (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // op[1:0], coefficient[33:2], power[41:34], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // status[2:0], coefficient_out[34:3], power_out[43:35], pad
    output logic        m_tlast    // last
);
    import spm_pkg::*;

    state_t state_reg, state_next;

    logic [TCNT_W-1:0] na_reg, nb_reg;
    logic [PCNT_W-1:0] np_reg;
    logic              tsel_reg;                 // 0 first table, 1 second
    logic [COEF_W-1:0] cin_reg;
    logic [POW_W-1:0]  pin_reg;
    logic [TIDX_W-1:0] i_reg, j_reg;
    logic [PCNT_W-1:0] k_reg;
    logic [COEF_W-1:0] pc_reg;
    logic [PPOW_W-1:0] pp_reg;
    logic              rd_pend_reg;              // RAM read data valid this cycle
    logic              merge_reg;
    logic [2:0]        rsp_st_reg;               // status for the single-word response

    // output register
    logic              ov_reg;
    logic [2:0]        ost_reg;
    logic [COEF_W-1:0] oc_reg;
    logic [PPOW_W-1:0] op_reg;
    logic              ol_reg;

    // RAM ports
    logic              a_we, b_we, p_we;
    logic [TIDX_W-1:0] a_addr, b_addr;
    logic [PIDX_W-1:0] p_addr;
    logic [TERM_W-1:0] a_wd, b_wd, a_rd, b_rd;
    logic [PTERM_W-1:0] p_wd, p_rd;

    spm_ram #(.WIDTH(TERM_W), .DEPTH(TERMS)) u_ram_a (
        .clk(clk), .we(a_we), .addr(a_addr), .wdata(a_wd), .rdata(a_rd));
    spm_ram #(.WIDTH(TERM_W), .DEPTH(TERMS)) u_ram_b (
        .clk(clk), .we(b_we), .addr(b_addr), .wdata(b_wd), .rdata(b_rd));
    spm_ram #(.WIDTH(PTERM_W), .DEPTH(PDEPTH)) u_ram_p (
        .clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wd), .rdata(p_rd));

    logic out_free;
    assign out_free = !ov_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tlast  = ol_reg;
    assign m_tdata  = {4'd0, op_reg, oc_reg, ost_reg};

    logic [TCNT_W-1:0] ncur;
    logic [TERM_W-1:0] tcur;
    assign ncur = tsel_reg ? nb_reg : na_reg;
    assign tcur = tsel_reg ? b_rd : a_rd;

    logic [COEF_W-1:0] prod;
    assign prod = a_rd[COEF_W-1:0] * b_rd[COEF_W-1:0];

    logic [PPOW_W-1:0] psum;
    assign psum = {1'b0, a_rd[TERM_W-1:COEF_W]} + {1'b0, b_rd[TERM_W-1:COEF_W]};

    // control and datapath
    always_comb
    begin
        a_we = 1'b0; b_we = 1'b0; p_we = 1'b0;
        a_addr = i_reg; b_addr = j_reg; p_addr = k_reg[PIDX_W-1:0];
        a_wd = '0; b_wd = '0; p_wd = {pp_reg, pc_reg};
        if (state_reg == S_SCAN || state_reg == S_ADDWR)
        begin
            a_addr = i_reg; b_addr = i_reg;
        end
        if (state_reg == S_ADDWR)
        begin
            // cin_reg already holds the merged sum on a merge
            a_we = !tsel_reg; b_we = tsel_reg;
            a_wd = {pin_reg, cin_reg};
            b_wd = {pin_reg, cin_reg};
        end
        if (state_reg == S_PWR)
        begin
            p_we = 1'b1;
        end
    end

    logic [TCNT_W-1:0] na_next, nb_next;
    logic [PCNT_W-1:0] np_next, k_next;
    logic [TIDX_W-1:0] i_next, j_next;
    logic              ov_next, ol_next, merge_next, rd_pend_next, tsel_next;
    logic [2:0]        ost_next, rsp_st_next;
    logic [COEF_W-1:0] oc_next, pc_next, cin_next;
    logic [PPOW_W-1:0] op_next, pp_next;
    logic [POW_W-1:0]  pin_next;

    always_comb
    begin
        state_next = state_reg;
        na_next = na_reg; nb_next = nb_reg; np_next = np_reg;
        i_next = i_reg; j_next = j_reg; k_next = k_reg;
        ov_next = ov_reg && !m_tready;
        ost_next = ost_reg; oc_next = oc_reg; op_next = op_reg; ol_next = ol_reg;
        rsp_st_next = rsp_st_reg;
        merge_next = merge_reg; rd_pend_next = 1'b0; tsel_next = tsel_reg;
        pc_next = pc_reg; pp_next = pp_reg; cin_next = cin_reg; pin_next = pin_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cin_next = s_tdata[33:2];
                    pin_next = s_tdata[41:34];
                    i_next = '0; j_next = '0; k_next = '0;
                    merge_next = 1'b0;
                    unique case (op_t'(s_tdata[1:0]))
                        OP_ADD_FIRST, OP_ADD_SECOND:
                        begin
                            tsel_next = s_tdata[0];
                            state_next = S_SCAN;
                        end
                        OP_CLEAR:
                        begin
                            na_next = '0; nb_next = '0; np_next = '0;
                            rsp_st_next = ST_CLEARED;
                            state_next = S_RESP;
                        end
                        OP_PRODUCT:
                        begin
                            np_next = '0;
                            if (na_reg == '0 || nb_reg == '0)
                            begin
                                rsp_st_next = ST_EMPTY;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_PRD;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                // rd_pend_reg: data for i_reg-1 is on the RAM output
                if (rd_pend_reg && tcur[TERM_W-1:COEF_W] == pin_reg)
                begin
                    merge_next = 1'b1;
                    cin_next = tcur[COEF_W-1:0] + cin_reg;
                    i_next = i_reg - 1'b1;
                    state_next = S_ADDWR;
                end
                else if ((!rd_pend_reg && ncur == '0) ||
                         (rd_pend_reg && ({1'b0, i_reg} == ncur ||
                                          (i_reg == '0 && ncur == TCNT_W'(TERMS)))))
                begin
                    // searched every stored term
                    if (ncur == TCNT_W'(TERMS))
                    begin
                        rsp_st_next = ST_DROPPED;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        i_next = ncur[TIDX_W-1:0];
                        state_next = S_ADDWR;
                    end
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    rd_pend_next = 1'b1;
                end
            end
            S_ADDWR:
            begin
                if (merge_reg)
                begin
                    rsp_st_next = ST_MERGED;
                end
                else
                begin
                    rsp_st_next = ST_APPENDED;
                    if (tsel_reg) nb_next = nb_reg + 1'b1;
                    else na_next = na_reg + 1'b1;
                end
                state_next = S_RESP;
            end
            S_PRD:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                pc_next = prod;
                pp_next = psum;
                k_next = '0;
                merge_next = 1'b0;
                state_next = S_PSCAN;
            end
            S_PSCAN:
            begin
                if (rd_pend_reg && p_rd[PTERM_W-1:COEF_W] == pp_reg)
                begin
                    merge_next = 1'b1;
                    pc_next = p_rd[COEF_W-1:0] + pc_reg;
                    k_next = k_reg - 1'b1;
                    state_next = S_PWR;
                end
                else if (k_reg == np_reg)
                begin
                    state_next = S_PWR;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    rd_pend_next = 1'b1;
                end
            end
            S_PWR:
            begin
                if (!merge_reg) np_next = np_reg + 1'b1;
                if ({1'b0, j_reg} == nb_reg - 1'b1)
                begin
                    j_next = '0;
                    if ({1'b0, i_reg} == na_reg - 1'b1)
                    begin
                        k_next = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                        state_next = S_PRD;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    state_next = S_PRD;
                end
            end
            S_EMIT:
            begin
                state_next = S_EMITW;
            end
            S_EMITW:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    ost_next = ST_TERM;
                    oc_next = p_rd[COEF_W-1:0];
                    op_next = p_rd[PTERM_W-1:COEF_W];
                    ol_next = (k_reg + 1'b1 == np_reg);
                    k_next = k_reg + 1'b1;
                    state_next = (k_reg + 1'b1 == np_reg) ? S_IDLE : S_EMIT;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    ost_next = rsp_st_reg;
                    oc_next = '0; op_next = '0; ol_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            na_reg <= '0; nb_reg <= '0; np_reg <= '0;
            ov_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            na_reg <= na_next; nb_reg <= nb_next; np_reg <= np_next;
            ov_reg <= ov_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next; j_reg <= j_next; k_reg <= k_next;
        ost_reg <= ost_next; oc_reg <= oc_next; op_reg <= op_next; ol_reg <= ol_next;
        rsp_st_reg <= rsp_st_next;
        merge_reg <= merge_next; tsel_reg <= tsel_next;
        pc_reg <= pc_next; pp_reg <= pp_next; cin_reg <= cin_next; pin_reg <= pin_next;
    end

    // table counts never exceed capacity
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        na_reg <= TCNT_W'(TERMS) && nb_reg <= TCNT_W'(TERMS))
        else $error("term count overflow");
    // product count bounded by the product table depth
    a_pcnt: assert property (@(posedge clk) disable iff (!rst_n)
        np_reg <= PCNT_W'(PDEPTH))
        else $error("product count overflow");
    // no new input while a word is being produced
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("ready while busy");
    // a clear empties both term tables
    a_clr: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tdata[1:0] == OP_CLEAR) |=> (na_reg == '0 && nb_reg == '0))
        else $error("clear failed");

endmodule
